@@ rtl/core/larq_pkg.sv @@
// larq_pkg: shared constants and types of the line assembling receive queue
// holds command codes, character codes, field widths and parameter defaults
// no dependencies
package larq_pkg;

  // parameter defaults
  localparam int LineCountDefault = 4;
  localparam int LineSizeDefault  = 64;

  // field widths
  localparam int CmdW     = 2;
  localparam int ByteW    = 8;
  localparam int OffW     = 6;
  localparam int WaitW    = 2;
  localparam int OLenW    = 6;
  localparam int InDataW  = 16;
  localparam int OutDataW = 24;

  // line end characters
  localparam logic [ByteW-1:0] CH_LF = 8'h0A;
  localparam logic [ByteW-1:0] CH_CR = 8'h0D;

  // transaction commands
  typedef enum logic [CmdW-1:0] {
    CMD_RX      = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

endpackage

@@ rtl/core/line_assembling_receive_queue.sv @@
// line_assembling_receive_queue: assembles received bytes into lines kept in
// a ring of line slots in a byte memory, with one length memory entry per slot
// depends on larq_pkg
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+--------------------------------------
// s_*      | in  | s_tvalid/s_tready  | command, rx_byte, read_offset
// m_*      | out | m_tvalid/m_tready  | line_ready, lines_waiting, read_byte,
//          |     |                    | oldest_length
// cfg_*    | in  | cfg_we             | filter_empty_lines
//
// one transaction per cycle sustained while m_tready is high; each result
// passes through the read of the line memories and then the output register.
// rst is synchronous and clears the ring pointers, counts and the pipeline;
// the memories keep their contents; the result masks out unwritten reads.
// a stalled m_tready holds the output register and then the read stage;
// s_tready drops only when both are full.
module line_assembling_receive_queue #(
  parameter int LINE_COUNT = larq_pkg::LineCountDefault,
  parameter int LINE_SIZE  = larq_pkg::LineSizeDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,   // filter_empty_lines
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [1:0] command, [9:2] rx_byte, [15:10] read_offset
  input  logic [larq_pkg::InDataW-1:0]  s_tdata,
  // output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] line_ready, [2:1] lines_waiting, [10:3] read_byte,
  // [16:11] oldest_length, [23:17] zero
  output logic [larq_pkg::OutDataW-1:0] m_tdata
);

  localparam int SW     = (LINE_COUNT > 2) ? $clog2(LINE_COUNT) : 1;
  localparam int LW     = $clog2(LINE_SIZE);
  localparam int FW     = $clog2(LINE_SIZE + 1);
  localparam int AW     = $clog2(LINE_COUNT * LINE_SIZE);
  localparam int DEPTH  = LINE_COUNT * LINE_SIZE;
  localparam int CMPW   = 9;

  localparam logic [SW-1:0] SLOT_LAST = SW'(LINE_COUNT - 1);
  localparam logic [SW-1:0] CNT_MAX   = SW'(LINE_COUNT - 1);
  localparam logic [FW-1:0] FILL_MAX  = FW'(LINE_SIZE);
  localparam logic [LW-1:0] LEN_CLAMP = LW'(LINE_SIZE - 1);

  // memories
  logic [larq_pkg::ByteW-1:0] line_store [DEPTH];
  logic [LW-1:0]              line_lengths [LINE_COUNT];

  // control state
  logic          filter_empty;
  logic [SW-1:0] count, count_next;
  logic [SW-1:0] oldest, oldest_next;
  logic [SW-1:0] newest, newest_next;
  logic [FW-1:0] fill, fill_next;
  logic          after_cr, after_cr_next;

  // input fields
  larq_pkg::cmd_t             in_cmd;
  logic [larq_pkg::ByteW-1:0] in_byte;
  logic [larq_pkg::OffW-1:0]  in_off;

  // memory access
  logic          byte_we, byte_re;
  logic [AW-1:0] byte_waddr, byte_raddr;
  logic [larq_pkg::ByteW-1:0] byte_rdata;
  logic          len_we;
  logic [LW-1:0] len_wdata, len_rdata;

  // read stage
  logic                       s1_valid;
  logic                       s1_read_ok;
  logic [larq_pkg::OffW-1:0]  s1_off;
  logic [SW-1:0]              s1_count;
  logic                       s1_fwd;
  logic [LW-1:0]              s1_fwd_len;
  logic                       s1_adv;
  logic                       accept;

  // result
  logic [LW-1:0]              len_eff;
  logic [larq_pkg::ByteW-1:0] res_byte;
  logic [SW+1:0]              cnt_ext;
  logic [LW+larq_pkg::OLenW-1:0] len_ext;
  logic [larq_pkg::OutDataW-1:0] res_data;

  assign in_cmd  = larq_pkg::cmd_t'(s_tdata[1:0]);
  assign in_byte = s_tdata[9:2];
  assign in_off  = s_tdata[15:10];

  // handshake: output register frees the read stage, read stage frees input
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + SW'(1);
  endfunction

  // next control state and memory requests for the transaction
  always_comb begin
    logic is_lf, is_cr;
    is_lf         = (in_byte == larq_pkg::CH_LF);
    is_cr         = (in_byte == larq_pkg::CH_CR);
    count_next    = count;
    oldest_next   = oldest;
    newest_next   = newest;
    fill_next     = fill;
    after_cr_next = after_cr;
    byte_we       = 1'b0;
    len_we        = 1'b0;
    len_wdata     = (fill >= FILL_MAX) ? LEN_CLAMP : fill[LW-1:0];
    byte_waddr    = AW'(AW'(newest) * AW'(LINE_SIZE) + AW'(fill));
    unique case (in_cmd)
      larq_pkg::CMD_RX: begin
        if (after_cr && is_lf) begin
          // second half of a crlf pair
        end else if (is_lf || is_cr) begin
          if (!(filter_empty && fill == '0)) begin
            if (count < CNT_MAX) begin
              len_we      = 1'b1;
              newest_next = next_slot(newest);
              count_next  = count + SW'(1);
            end
            fill_next = '0;
          end
        end else if (fill < FILL_MAX) begin
          byte_we   = 1'b1;
          fill_next = fill + FW'(1);
        end
        after_cr_next = is_cr;
      end
      larq_pkg::CMD_RELEASE: begin
        if (count != '0) begin
          oldest_next = next_slot(oldest);
          count_next  = count - SW'(1);
        end
      end
      default: begin
        // read and unused code leave the state alone
      end
    endcase
  end

  assign byte_raddr = AW'(AW'(oldest) * AW'(LINE_SIZE) + AW'(in_off));
  assign byte_re    = accept && (in_cmd == larq_pkg::CMD_READ)
                      && (32'(in_off) < LINE_SIZE);

  // control state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_empty <= 1'b0;
      count        <= '0;
      oldest       <= '0;
      newest       <= '0;
      fill         <= '0;
      after_cr     <= 1'b0;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        filter_empty <= cfg_wdata;
      end
      if (accept) begin
        count    <= count_next;
        oldest   <= oldest_next;
        newest   <= newest_next;
        fill     <= fill_next;
        after_cr <= after_cr_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // read stage payload, with bypass of a length written to the slot read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read_ok <= (in_cmd == larq_pkg::CMD_READ) && (count != '0);
      s1_off     <= in_off;
      s1_count   <= count_next;
      s1_fwd     <= len_we && (newest == oldest_next);
      s1_fwd_len <= len_wdata;
    end
  end

  // byte memory
  always_ff @(posedge clk) begin
    if (accept && byte_we) begin
      line_store[byte_waddr] <= in_byte;
    end
    if (byte_re) begin
      byte_rdata <= line_store[byte_raddr];
    end
  end

  // length memory, read at the oldest slot after the transaction
  always_ff @(posedge clk) begin
    if (accept && len_we) begin
      line_lengths[newest] <= len_wdata;
    end
    if (accept) begin
      len_rdata <= line_lengths[oldest_next];
    end
  end

  // result assembly
  always_comb begin
    len_eff  = s1_fwd ? s1_fwd_len : len_rdata;
    res_byte = (s1_read_ok && (CMPW'(s1_off) < CMPW'(len_eff))) ? byte_rdata : '0;
    cnt_ext  = {2'b00, s1_count};
    len_ext  = (s1_count != '0) ? {{larq_pkg::OLenW{1'b0}}, len_eff} : '0;
    res_data = '0;
    res_data[0]     = (s1_count != '0);
    res_data[2:1]   = cnt_ext[1:0];
    res_data[10:3]  = res_byte;
    res_data[16:11] = len_ext[larq_pkg::OLenW-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= res_data;
    end
  end

  // a release with lines waiting drops the count by one
  assert property (@(posedge clk) disable iff (rst)
    accept && in_cmd == larq_pkg::CMD_RELEASE && count != '0
    |=> count == $past(count) - SW'(1))
    else $error("release did not drop the line count");

  // a stalled read stage keeps its result
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_count) && $stable(s1_off))
    else $error("read stage lost its transaction while stalled");

  // the queue never holds more than one slot short of the ring
  assert property (@(posedge clk) disable iff (rst)
    accept && count == CNT_MAX |=> count <= CNT_MAX && fill <= FILL_MAX)
    else $error("line queue overran its ring");

endmodule
